// File: src/tbpc_pkg.sv
`timescale 1ns / 1ps

package tbpc_pkg;

    localparam int CNT_W    = 16;
    localparam int EVENT_W  = 3;
    localparam int MAX_EV   = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // input command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_EDGE = 1'b1;

    // pin codes
    localparam logic [1:0] PIN_PWR  = 2'd0;
    localparam logic [1:0] PIN_USR  = 2'd1;
    localparam logic [1:0] PIN_PINT = 2'd2;

    // pin levels
    localparam logic LVL_PRESSED  = 1'b0;
    localparam logic LVL_RELEASED = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PWR_OFF_TICKS        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PWR_SHORT_TICKS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_USR_SHORT_TICKS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_USR_MEDIUM_LOW_TICKS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_USR_XLONG_TICKS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CALIBRATE_PRESSES    = 3'd5;

    typedef enum logic [EVENT_W-1:0] {
        EV_PWR_SHORT  = 3'd0,
        EV_USR_SHORT  = 3'd1,
        EV_USR_MEDIUM = 3'd2,
        EV_CHIP_INT   = 3'd3,
        EV_USR_XLONG  = 3'd4,
        EV_CALIBRATE  = 3'd5,
        EV_PWR_LONG   = 3'd6
    } event_t;

    // events caused by one input transaction, in emission order
    typedef struct packed {
        logic [1:0]                       cnt;
        logic [MAX_EV-1:0][EVENT_W-1:0]   ev;
    } ev_bundle_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
    endfunction

endpackage

// File: src/tbpc_core.sv
`timescale 1ns / 1ps

module tbpc_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [tbpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tbpc_pkg::CNT_W-1:0]          cfg_wdata,
    input  logic                                accept,
    input  logic                                cmd,
    input  logic [1:0]                          pin,
    input  logic                                level,
    output tbpc_pkg::ev_bundle_t                bundle,
    output logic                                push
);

    logic [tbpc_pkg::CNT_W-1:0] pwr_off_reg;
    logic [tbpc_pkg::CNT_W-1:0] pwr_short_reg;
    logic [tbpc_pkg::CNT_W-1:0] usr_short_reg;
    logic [tbpc_pkg::CNT_W-1:0] usr_med_low_reg;
    logic [tbpc_pkg::CNT_W-1:0] usr_xlong_reg;
    logic [tbpc_pkg::CNT_W-1:0] cal_presses_reg;

    logic                       pwr_level_reg, pwr_level_next;
    logic                       usr_level_reg, usr_level_next;
    logic [tbpc_pkg::CNT_W-1:0] pwr_cnt_reg, pwr_cnt_next;
    logic [tbpc_pkg::CNT_W-1:0] usr_cnt_reg, usr_cnt_next;
    logic [tbpc_pkg::CNT_W-1:0] press_total_reg, press_total_next;
    logic                       long_fired_reg, long_fired_next;

    // one flag per event source, compacted into the bundle below
    logic f_edge;
    logic f_xlong;
    logic f_cal;
    logic f_long;
    tbpc_pkg::event_t edge_ev;

    always_comb begin
        pwr_level_next   = pwr_level_reg;
        usr_level_next   = usr_level_reg;
        pwr_cnt_next     = pwr_cnt_reg;
        usr_cnt_next     = usr_cnt_reg;
        press_total_next = press_total_reg;
        long_fired_next  = long_fired_reg;
        f_edge  = 1'b0;
        f_xlong = 1'b0;
        f_cal   = 1'b0;
        f_long  = 1'b0;
        edge_ev = tbpc_pkg::EV_CHIP_INT;

        if (cmd == tbpc_pkg::CMD_EDGE) begin
            if (pin == tbpc_pkg::PIN_PWR) begin
                if (level != pwr_level_reg) begin
                    pwr_level_next = level;
                    if (level == tbpc_pkg::LVL_RELEASED) begin
                        if (pwr_cnt_reg < pwr_short_reg) begin
                            f_edge  = 1'b1;
                            edge_ev = tbpc_pkg::EV_PWR_SHORT;
                        end
                        long_fired_next = 1'b0;
                    end else begin
                        pwr_cnt_next = '0;
                    end
                end
            end else if (pin == tbpc_pkg::PIN_USR) begin
                if (level != usr_level_reg) begin
                    usr_level_next = level;
                    if (level == tbpc_pkg::LVL_RELEASED) begin
                        if (usr_cnt_reg != '0 && usr_cnt_reg < usr_short_reg) begin
                            f_edge  = 1'b1;
                            edge_ev = tbpc_pkg::EV_USR_SHORT;
                        end else if (usr_cnt_reg > usr_med_low_reg &&
                                     usr_cnt_reg < usr_xlong_reg) begin
                            f_edge  = 1'b1;
                            edge_ev = tbpc_pkg::EV_USR_MEDIUM;
                        end
                    end else begin
                        press_total_next = tbpc_pkg::sat_inc(press_total_reg);
                        usr_cnt_next     = '0;
                    end
                end
            end else if (pin == tbpc_pkg::PIN_PINT) begin
                f_edge  = 1'b1;
                edge_ev = tbpc_pkg::EV_CHIP_INT;
            end
        end else begin
            if (usr_level_reg == tbpc_pkg::LVL_PRESSED) begin
                usr_cnt_next = tbpc_pkg::sat_inc(usr_cnt_reg);
                f_xlong      = (usr_cnt_next >= usr_xlong_reg);
            end
            if (pwr_level_reg == tbpc_pkg::LVL_PRESSED) begin
                if (!long_fired_reg) begin
                    pwr_cnt_next = tbpc_pkg::sat_inc(pwr_cnt_reg);
                end
                if (pwr_cnt_next >= pwr_off_reg) begin
                    f_cal = (press_total_reg == cal_presses_reg) &&
                            (usr_level_reg == tbpc_pkg::LVL_PRESSED);
                    if (!long_fired_reg) begin
                        f_long          = 1'b1;
                        long_fired_next = 1'b1;
                    end
                end
            end
        end
    end

    // pack flagged events in order: edge/xlong, calibrate, power long
    always_comb begin
        bundle.cnt = 2'd0;
        bundle.ev  = '0;
        if (f_edge) begin
            bundle.ev[bundle.cnt] = edge_ev;
            bundle.cnt            = bundle.cnt + 2'd1;
        end
        if (f_xlong) begin
            bundle.ev[bundle.cnt] = tbpc_pkg::EV_USR_XLONG;
            bundle.cnt            = bundle.cnt + 2'd1;
        end
        if (f_cal) begin
            bundle.ev[bundle.cnt] = tbpc_pkg::EV_CALIBRATE;
            bundle.cnt            = bundle.cnt + 2'd1;
        end
        if (f_long) begin
            bundle.ev[bundle.cnt] = tbpc_pkg::EV_PWR_LONG;
            bundle.cnt            = bundle.cnt + 2'd1;
        end
    end

    assign push = accept && (bundle.cnt != 2'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pwr_off_reg     <= 16'd200;
            pwr_short_reg   <= 16'd50;
            usr_short_reg   <= 16'd50;
            usr_med_low_reg <= 16'd200;
            usr_xlong_reg   <= 16'd500;
            cal_presses_reg <= 16'd2;
            pwr_level_reg   <= tbpc_pkg::LVL_RELEASED;
            usr_level_reg   <= tbpc_pkg::LVL_RELEASED;
            pwr_cnt_reg     <= '0;
            usr_cnt_reg     <= '0;
            press_total_reg <= '0;
            long_fired_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    tbpc_pkg::REG_PWR_OFF_TICKS:        pwr_off_reg     <= cfg_wdata;
                    tbpc_pkg::REG_PWR_SHORT_TICKS:      pwr_short_reg   <= cfg_wdata;
                    tbpc_pkg::REG_USR_SHORT_TICKS:      usr_short_reg   <= cfg_wdata;
                    tbpc_pkg::REG_USR_MEDIUM_LOW_TICKS: usr_med_low_reg <= cfg_wdata;
                    tbpc_pkg::REG_USR_XLONG_TICKS:      usr_xlong_reg   <= cfg_wdata;
                    tbpc_pkg::REG_CALIBRATE_PRESSES:    cal_presses_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (accept) begin
                pwr_level_reg   <= pwr_level_next;
                usr_level_reg   <= usr_level_next;
                pwr_cnt_reg     <= pwr_cnt_next;
                usr_cnt_reg     <= usr_cnt_next;
                press_total_reg <= press_total_next;
                long_fired_reg  <= long_fired_next;
            end
        end
    end

endmodule

// File: src/tbpc_drain.sv
`timescale 1ns / 1ps

module tbpc_drain (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  tbpc_pkg::ev_bundle_t                bundle,
    input  logic                                push,
    output logic                                in_ready,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [tbpc_pkg::EVENT_W-1:0]        m_event_res,
    output logic                                m_last
);

    localparam int DEPTH = 2;

    tbpc_pkg::ev_bundle_t       buf_reg [DEPTH];
    logic                       wr_ptr_reg, wr_ptr_next;
    logic                       rd_ptr_reg, rd_ptr_next;
    logic [1:0]                 fill_reg, fill_next;
    logic [1:0]                 idx_reg, idx_next;
    tbpc_pkg::ev_bundle_t       head;
    logic                       pop;

    assign head        = buf_reg[rd_ptr_reg];
    assign m_valid     = (fill_reg != 2'd0);
    assign m_event_res = head.ev[idx_reg];
    assign m_last      = ((idx_reg + 2'd1) == head.cnt);
    assign in_ready    = (fill_reg != 2'(DEPTH));

    // a bundle leaves once its final event transaction completes
    assign pop = m_valid && m_ready && m_last;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
        idx_next    = idx_reg;
        if (m_valid && m_ready) begin
            idx_next = m_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
            idx_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= bundle;
        end
    end

endmodule

// File: src/two_button_press_classifier.sv
`timescale 1ns / 1ps

// Classifies power and user button presses from pin-edge and tick transactions and
// reports power short, user short/medium, interrupt, user extra-long, calibrate and
// power long events. An input transaction is taken every cycle as long as the two-entry
// event queue has room; its state update happens in the cycle it is accepted. Each
// input produces zero to three event transactions, delivered one per cycle while m_ready
// is high, in order with m_last marking the final one; the output side therefore sets
// the sustained rate when inputs cause several events. Inputs that cause no event never
// enter the queue. Threshold registers are written through cfg_we/cfg_index/cfg_wdata.
module two_button_press_classifier (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [tbpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tbpc_pkg::CNT_W-1:0]          cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_cmd,
    input  logic [1:0]                          s_pin,
    input  logic                                s_level,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [tbpc_pkg::EVENT_W-1:0]        m_event_res,
    output logic                                m_last
);

    tbpc_pkg::ev_bundle_t bundle;
    logic                 push;
    logic                 accept;

    assign accept = s_valid && s_ready;

    tbpc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .cmd       (s_cmd),
        .pin       (s_pin),
        .level     (s_level),
        .bundle    (bundle),
        .push      (push)
    );

    tbpc_drain u_drain (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .bundle      (bundle),
        .push        (push),
        .in_ready    (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_event_res (m_event_res),
        .m_last      (m_last)
    );

endmodule
